@@ rtl/core/ssfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_pkg
// shared constants, register indexes and types for the start/stop frame echo
// ----------------------------------------------------------------------------
package ssfe_pkg;

    // payload store geometry
    localparam int STORE_DEPTH = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int ECHO_MAX    = 16;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_COUNT  = 2'd3;

    // configuration reset values
    localparam logic [7:0] START_CODE_RST  = 8'd255;
    localparam logic [7:0] STOP_CODE_RST   = 8'd251;
    localparam logic [3:0] MAX_PAYLOAD_RST = 4'd11;
    localparam logic [4:0] ECHO_COUNT_RST  = 5'd7;

    // request command codes
    typedef enum logic [0:0] {
        CMD_LINE = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    // store write request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } store_wr_t;

    // store read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } store_rd_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_ECHO_RD,
        S_ECHO_WR,
        S_TAIL,
        S_READ_WR
    } state_t;

endpackage

@@ rtl/core/ssfe_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfe_store
// payload store: one write port, one registered read port, per-entry valid
// bits so that entries never written read as zero right after reset
// ----------------------------------------------------------------------------
module ssfe_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssfe_pkg::store_wr_t   wr,
    input  ssfe_pkg::store_rd_t   rd,
    output logic [7:0]            rd_data
);
    import ssfe_pkg::*;

    logic [7:0]             payload_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [7:0]             rd_data_reg;
    logic                   rd_vld_reg;

    // memory array, write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            payload_mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= payload_mem[rd.addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en)
            begin
                rd_vld_reg <= valid_reg[rd.addr];
            end
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : 8'd0;

endmodule

@@ rtl/core/start_stop_frame_echo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// start_stop_frame_echo
// start/stop code byte framing with payload store, echo reply and read-back
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  in       | in_valid / in_stall         | cmd, rx_byte, read_index
//  out      | out_valid / out_stall       | out_byte, is_read_reply, last
//  config   | cfg_write                   | cfg_index, cfg_data
//
//  a line byte that stores, opens or is ignored leaves the sequencer idle
//  a read is one memory read, then the output register load, which output stalls hold
//  a frame reply is the head load, then for each echoed byte one read of the single store
//  port and one output register load, then the tail load; output stalls hold every load
//  reset is asynchronous; store valid bits clear at once, so no clearing pass
//  out_stall holds the output register and sequencer loads; a new request is taken only in idle, also while it waits
// ----------------------------------------------------------------------------
module start_stop_frame_echo (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             cfg_write,
    input  logic [ssfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data,
    // input requests
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cmd,
    input  logic [7:0]                       rx_byte,
    input  logic [7:0]                       read_index,
    // results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_byte,
    output logic                             is_read_reply,
    output logic                             last
);
    import ssfe_pkg::*;

    // configuration registers
    logic [7:0] start_code_reg;
    logic [7:0] stop_code_reg;
    logic [3:0] max_payload_reg;
    logic [4:0] echo_count_reg;

    // control state
    state_t     state_reg, state_next;
    logic       in_frame_reg, in_frame_next;
    logic [3:0] wr_idx_reg, wr_idx_next;
    logic [3:0] k_reg, k_next;
    logic [4:0] echo_cnt_reg, echo_cnt_next;
    logic       zero_reg, zero_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       is_read_reg, is_read_next;
    logic       last_reg, last_next;
    logic       load;

    // store interface
    store_wr_t  wr;
    store_rd_t  rd;
    logic [7:0] rd_data;

    // decode helpers
    logic       in_accept;
    logic       out_free;
    logic       is_start;
    logic       is_end;
    logic [4:0] echo_clamp;
    logic       read_ok;
    logic       wr_ok;
    logic       k_ok;
    logic [7:0] wr_idx8;
    logic [7:0] k8;

    ssfe_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg  <= START_CODE_RST;
            stop_code_reg   <= STOP_CODE_RST;
            max_payload_reg <= MAX_PAYLOAD_RST;
            echo_count_reg  <= ECHO_COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_CODE:  start_code_reg  <= cfg_data;
                CFG_STOP_CODE:   stop_code_reg   <= cfg_data;
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[3:0];
                CFG_ECHO_COUNT:  echo_count_reg  <= cfg_data[4:0];
                default:         ;
            endcase
        end
    end

    // helpers
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign is_start   = (rx_byte == start_code_reg);
    assign is_end     = (rx_byte == stop_code_reg) || (wr_idx_reg >= max_payload_reg);
    assign echo_clamp = (echo_count_reg > 5'(ECHO_MAX)) ? 5'(ECHO_MAX) : echo_count_reg;
    assign wr_idx8    = {4'd0, wr_idx_reg};
    assign k8         = {4'd0, k_reg};
    assign read_ok    = (read_index <= {4'd0, max_payload_reg})
                        && ({1'b0, read_index} < 9'(STORE_DEPTH));
    assign wr_ok      = ({1'b0, wr_idx8} < 9'(STORE_DEPTH));
    assign k_ok       = ({1'b0, k8} < 9'(STORE_DEPTH));

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_frame_reg  <= 1'b0;
            wr_idx_reg    <= '0;
            k_reg         <= '0;
            echo_cnt_reg  <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_frame_reg  <= in_frame_next;
            wr_idx_reg    <= wr_idx_next;
            k_reg         <= k_next;
            echo_cnt_reg  <= echo_cnt_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= out_byte_next;
            is_read_reg  <= is_read_next;
            last_reg     <= last_next;
        end
    end

    // sequencer: next state, store requests, output loads
    always_comb
    begin
        state_next    = state_reg;
        in_frame_next = in_frame_reg;
        wr_idx_next   = wr_idx_reg;
        k_next        = k_reg;
        echo_cnt_next = echo_cnt_reg;
        zero_next     = zero_reg;
        load          = 1'b0;
        out_byte_next = 8'd0;
        is_read_next  = 1'b0;
        last_next     = 1'b0;
        wr.en         = 1'b0;
        wr.addr       = wr_idx8[IDX_W-1:0];
        wr.data       = rx_byte;
        rd.en         = 1'b0;
        rd.addr       = k8[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        rd.en      = read_ok;
                        rd.addr    = read_index[IDX_W-1:0];
                        zero_next  = !read_ok;
                        state_next = S_READ_WR;
                    end
                    else if (is_start)
                    begin
                        in_frame_next = 1'b1;
                        wr_idx_next   = '0;
                    end
                    else if (is_end)
                    begin
                        echo_cnt_next = echo_clamp;
                        in_frame_next = 1'b0;
                        wr_idx_next   = '0;
                        state_next    = S_HEAD;
                    end
                    else if (in_frame_reg)
                    begin
                        wr.en       = wr_ok;
                        wr_idx_next = wr_idx_reg + 4'd1;
                    end
                end
            end
            S_HEAD:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = start_code_reg;
                    k_next        = '0;
                    state_next    = (echo_cnt_reg == 5'd0) ? S_TAIL : S_ECHO_RD;
                end
            end
            S_ECHO_RD:
            begin
                rd.en      = k_ok;
                zero_next  = !k_ok;
                state_next = S_ECHO_WR;
            end
            S_ECHO_WR:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = zero_reg ? 8'd0 : rd_data;
                    k_next        = k_reg + 4'd1;
                    state_next    = (5'(k_reg) + 5'd1 == echo_cnt_reg) ? S_TAIL : S_ECHO_RD;
                end
            end
            S_TAIL:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = stop_code_reg;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_READ_WR:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_byte_next = zero_reg ? 8'd0 : rd_data;
                    is_read_next  = 1'b1;
                    last_next     = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register valid
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ports
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_read_reply = is_read_reg;
    assign last          = last_reg;

    // a read request always busies the block for its answer
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cmd == CMD_READ) |=> in_stall)
        else $error("read request did not hold off the input");

    // the tail load puts the stop code out, marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAIL && out_free) |=>
            (out_valid && last && !is_read_reply && out_byte == stop_code_reg))
        else $error("frame reply did not end in the stop code");

    // a read answer is always a single, last result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_read_reply) |-> last)
        else $error("read answer not marked last");

    // a frame end clears the frame state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && state_next == S_HEAD) |=>
            (!in_frame_reg && wr_idx_reg == 4'd0))
        else $error("frame state not cleared at frame end");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the start/stop frame echo: a directed table, then
// random frames, reads and noise under several settings, with random idling
// on both sides and one long output hold-off that backs up the request side
// ----------------------------------------------------------------------------
module testbench;
    import ssfe_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 48;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS    = 120;
    localparam int PHASE_ITEMS     = 24;
    localparam int PRINT_CAP       = 40;
    localparam int N_DIRECTED      = 34;

    // directed row kinds
    typedef enum logic [0:0] {
        ROW_REQ = 1'b0,
        ROW_SET = 1'b1
    } row_kind_t;

    typedef struct packed {
        logic [7:0] data;
        logic       rd;
        logic       last;
    } reply_t;

    typedef struct packed {
        row_kind_t            kind;
        cmd_t                 op;
        logic [7:0]           rx;
        logic [7:0]           ridx;
        logic                 known;
        logic [7:0]           known_byte;
        logic [CFG_IDX_W-1:0] reg_sel;
        logic [7:0]           reg_val;
    } stim_row_t;

    // dut ports
    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [7:0]           rx_byte;
    logic [7:0]           read_index;
    logic                 out_valid;
    logic                 out_stall;
    logic [7:0]           out_byte;
    logic                 is_read_reply;
    logic                 last;

    // predicted block state and settings
    logic [7:0] frame_store [STORE_DEPTH];
    logic [4:0] frame_wr_idx;
    logic       frame_open;
    logic [7:0] set_start;
    logic [7:0] set_stop;
    logic [3:0] set_limit;
    logic [4:0] set_echo;

    reply_t reply_ledger [$];
    reply_t head_reply;
    int     errors;
    int     requests_counted;
    int     cycles;
    bit     calm;
    bit     hold_off_req;
    bit     hold_off_done;

    // directed table: typed expectations only where obvious
    stim_row_t directed [N_DIRECTED] = '{
        // reads right after reset, then above the limit
        '{ROW_REQ, CMD_READ, 8'h00, 8'h00, 1'b1, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_READ, 8'hFF, 8'hFF, 1'b1, 8'h00, CFG_START_CODE, 8'h00},
        // stop with no frame open, then an ignored byte
        '{ROW_REQ, CMD_LINE, 8'hFB, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h00, 8'hFF, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        // plain frame with reset codes
        '{ROW_REQ, CMD_LINE, 8'hFF, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'hAA, 8'h55, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h55, 8'hAA, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'hFB, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_READ, 8'h00, 8'h01, 1'b1, 8'h55, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_READ, 8'hFF, 8'h0B, 1'b1, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_READ, 8'h00, 8'h0C, 1'b1, 8'h00, CFG_START_CODE, 8'h00},
        // start and stop codes equal: start wins
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h3C},
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_STOP_CODE, 8'h3C},
        '{ROW_REQ, CMD_LINE, 8'h3C, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h01, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        // zero limit: any non-start byte replies, open or not
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_STOP_CODE, 8'hC3},
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_MAX_PAYLOAD, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h77, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h10, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        // no echoed bytes
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_MAX_PAYLOAD, 8'h0F},
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_ECHO_COUNT, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h3C, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h81, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'hC3, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        // echo count above the store size clamps
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_ECHO_COUNT, 8'h1F},
        '{ROW_REQ, CMD_LINE, 8'hC3, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        // limit lowered while a frame is open
        '{ROW_REQ, CMD_LINE, 8'h3C, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h11, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h22, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_LINE, 8'h33, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_SET, CMD_LINE, 8'h00, 8'h00, 1'b0, 8'h00, CFG_MAX_PAYLOAD, 8'h02},
        '{ROW_REQ, CMD_LINE, 8'h44, 8'h00, 1'b0, 8'h00, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_READ, 8'h00, 8'h02, 1'b1, 8'h33, CFG_START_CODE, 8'h00},
        '{ROW_REQ, CMD_READ, 8'hFF, 8'h03, 1'b1, 8'h00, CFG_START_CODE, 8'h00}
    };

    start_stop_frame_echo dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_read_reply(is_read_reply),
        .last         (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // stored byte, zero past the end of the store
    function automatic logic [7:0] store_peek(input int idx);
        if (idx < STORE_DEPTH)
            return frame_store[idx];
        return 8'h00;
    endfunction

    // framing behavior for one accepted request; queues the bytes it sends back
    function automatic bit predict_request(input cmd_t op, input logic [7:0] b,
                                           input logic [7:0] ridx, input logic known,
                                           input logic [7:0] known_byte);
        reply_t r;
        int     n_echo;
        if (op == CMD_READ)
        begin
            r.data = (ridx <= set_limit) ? store_peek(int'(ridx)) : 8'h00;
            if (known)
                r.data = known_byte;
            r.rd   = 1'b1;
            r.last = 1'b1;
            reply_ledger.push_back(r);
            return 1'b0;
        end
        // start code always (re)opens
        if (b == set_start)
        begin
            frame_open   = 1'b1;
            frame_wr_idx = 5'd0;
            return 1'b0;
        end
        // stop code or limit reached: echo reply
        if (b == set_stop || frame_wr_idx >= set_limit)
        begin
            n_echo = (set_echo > ECHO_MAX) ? ECHO_MAX : int'(set_echo);
            reply_ledger.push_back('{set_start, 1'b0, 1'b0});
            for (int k = 0; k < n_echo; k++)
                reply_ledger.push_back('{store_peek(k), 1'b0, 1'b0});
            reply_ledger.push_back('{set_stop, 1'b0, 1'b1});
            frame_open   = 1'b0;
            frame_wr_idx = 5'd0;
            return 1'b0;
        end
        // payload byte, or ignored outside a frame
        if (frame_open)
        begin
            if (frame_wr_idx < STORE_DEPTH)
                frame_store[frame_wr_idx[3:0]] = b;
            frame_wr_idx = frame_wr_idx + 5'd1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // offer one request, hold it until taken, then maybe idle
    task automatic send_request(input cmd_t op, input logic [7:0] b,
                                input logic [7:0] ridx, input logic known,
                                input logic [7:0] known_byte);
        bit taken;
        in_valid   <= 1'b1;
        cmd        <= op;
        rx_byte    <= b;
        read_index <= ridx;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        if (!predict_request(op, b, ridx, known, known_byte))
            requests_counted++;
        while (!calm && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // block drained: all replies in, then a settling wait for silent requests
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (reply_ledger.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, mirrored into the predicted settings
    task automatic write_setting(input logic [CFG_IDX_W-1:0] sel, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (sel)
            CFG_START_CODE:  set_start = val;
            CFG_STOP_CODE:   set_stop  = val;
            CFG_MAX_PAYLOAD: set_limit = val[3:0];
            CFG_ECHO_COUNT:  set_echo  = val[4:0];
            default:         ;
        endcase
        @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 9);
        end
    end

    // result checker, sampled mid-cycle
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (reply_ledger.size() == 0)
                report_mismatch($sformatf("result %02h with nothing pending", out_byte));
            else
            begin
                head_reply = reply_ledger.pop_front();
                if (out_byte !== head_reply.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, head_reply.data));
                if (is_read_reply !== head_reply.rd)
                    report_mismatch($sformatf("is_read_reply %b, want %b",
                                              is_read_reply, head_reply.rd));
                if (last !== head_reply.last)
                    report_mismatch($sformatf("last %b, want %b", last, head_reply.last));
            end
        end
    end

    // stimulus
    initial
    begin
        int         phase;
        int         phase_end;
        int         shape;
        int         n_pay;
        logic [7:0] b;
        logic [7:0] ridx;
        logic [3:0] new_limit;
        logic [4:0] new_echo;

        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= CFG_START_CODE;
        cfg_data   <= 8'h00;
        in_valid   <= 1'b0;
        cmd        <= CMD_LINE;
        rx_byte    <= 8'h00;
        read_index <= 8'h00;
        errors           = 0;
        requests_counted = 0;
        calm             = 1'b0;
        hold_off_req     = 1'b0;
        hold_off_done    = 1'b0;

        // predicted state after reset
        for (int i = 0; i < STORE_DEPTH; i++)
            frame_store[i] = 8'h00;
        frame_wr_idx = 5'd0;
        frame_open   = 1'b0;
        set_start    = START_CODE_RST;
        set_stop     = STOP_CODE_RST;
        set_limit    = MAX_PAYLOAD_RST;
        set_echo     = ECHO_COUNT_RST;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed[i].kind == ROW_SET)
            begin
                wait_idle();
                write_setting(directed[i].reg_sel, directed[i].reg_val);
            end
            else
                send_request(directed[i].op, directed[i].rx, directed[i].ridx,
                             directed[i].known, directed[i].known_byte);
        end

        // random phases, each with fresh settings
        requests_counted = 0;
        phase = 0;
        while (requests_counted < RANDOM_ITEMS)
        begin
            wait_idle();
            case (phase % 4)
                1:
                begin
                    new_limit = 4'd15;
                    new_echo  = 5'd16;
                end
                2:
                begin
                    new_limit = 4'd1;
                    new_echo  = 5'd1;
                end
                3:
                begin
                    new_limit = 4'($urandom_range(0, 15));
                    new_echo  = 5'($urandom_range(0, 31));
                end
                default:
                begin
                    new_limit = 4'($urandom_range(1, 15));
                    new_echo  = 5'($urandom_range(1, 16));
                end
            endcase
            write_setting(CFG_START_CODE, 8'($urandom_range(0, 255)));
            write_setting(CFG_STOP_CODE, 8'($urandom_range(0, 255)));
            write_setting(CFG_MAX_PAYLOAD, {4'd0, new_limit});
            write_setting(CFG_ECHO_COUNT, {3'd0, new_echo});

            // one phase with no idling, one with the long output hold-off
            calm = (phase == 4);
            if (phase == 1)
                hold_off_req = 1'b1;

            phase_end = requests_counted + PHASE_ITEMS;
            while (requests_counted < phase_end)
            begin
                shape = $urandom_range(0, 99);
                if (shape < 70)
                begin
                    // frame: start, payload, usually a stop
                    send_request(CMD_LINE, set_start, 8'($urandom_range(0, 255)),
                                 1'b0, 8'h00);
                    n_pay = $urandom_range(0, int'(set_limit) + 1);
                    repeat (n_pay)
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == set_start || b == set_stop);
                        send_request(CMD_LINE, b, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                    end
                    if ($urandom_range(0, 99) < 85)
                        send_request(CMD_LINE, set_stop, 8'($urandom_range(0, 255)),
                                     1'b0, 8'h00);
                end
                else if (shape < 85)
                begin
                    // read, mostly near the limit
                    if ($urandom_range(0, 3) == 0)
                        ridx = 8'($urandom_range(0, 255));
                    else
                        ridx = 8'($urandom_range(0, int'(set_limit) + 1));
                    send_request(CMD_READ, 8'($urandom_range(0, 255)), ridx, 1'b0, 8'h00);
                end
                else
                    send_request(CMD_LINE, 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'b0, 8'h00);
            end
            phase++;
        end
        calm = 1'b0;

        // drain
        in_valid <= 1'b0;
        while (reply_ledger.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
